@@ sv/mfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mfa_pkg;

   localparam int FIELD_BITS = 61;
   localparam int ROUNDS = 61;
   localparam int ROUND_W = 6;
   localparam logic [FIELD_BITS-1:0] FIELD_P = {FIELD_BITS{1'b1}};
   localparam logic [63:0] INV_EXP = 64'h1FFF_FFFF_FFFF_FFFD;
   localparam logic [63:0] SQRT_EXP = 64'h0800_0000_0000_0000;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_MUL  = 2'd1,
      CMD_INV  = 2'd2,
      CMD_SQRT = 2'd3
   } cmd_type;

   // Tells whether the accumulator takes the product in a given round.
   function automatic logic exp_bit(input cmd_type cmd, input logic [ROUND_W-1:0] round);
      logic bit_value;
      unique case (cmd)
         CMD_ADD:  bit_value = 1'b0;
         CMD_MUL:  bit_value = (round == '0);
         CMD_INV:  bit_value = INV_EXP[round];
         CMD_SQRT: bit_value = SQRT_EXP[round];
         default:  bit_value = 1'b0;
      endcase
      return bit_value;
   endfunction

   // Maps the one pattern equal to the modulus to zero.
   function automatic logic [FIELD_BITS-1:0] reduce_in(input logic [FIELD_BITS-1:0] v);
      return (v == FIELD_P) ? '0 : v;
   endfunction

endpackage

`default_nettype wire

@@ sv/mfa_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mfa_req_if;
   import mfa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [FIELD_BITS-1:0] operand_a;
   logic [FIELD_BITS-1:0] operand_b;

   modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
   modport sink (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

@@ sv/mfa_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mfa_rsp_if;
   import mfa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] field_result;

   modport source (output valid, output field_result, input ready);
   modport sink (input valid, input field_result, output ready);
endinterface

`default_nettype wire

@@ sv/mersenne61_field_alu_unit.sv @@
// Channel | Direction | Word contents
// req_ch  | in        | cmd, operand_a, operand_b
// rsp_ch  | out       | field_result
// A new word enters each cycle while no result waits; each word passes through the entry register,
// 61 square-and-multiply rounds of three multiplier stages each, and the output register.
// Reset clears the valid bits of every stage and the output register.
// When the result waits, the whole pipeline holds and no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module mersenne61_field_alu_unit
   import mfa_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   mfa_req_if.sink   req_ch,
   mfa_rsp_if.source rsp_ch
);

   logic                  adv;
   logic                  v_s    [ROUNDS+1];
   cmd_type               cmd_s  [ROUNDS+1];
   logic [FIELD_BITS-1:0] acc_s  [ROUNDS+1];
   logic [FIELD_BITS-1:0] base_s [ROUNDS+1];

   logic                  ent_v_ff;
   cmd_type               ent_cmd_ff;
   logic [FIELD_BITS-1:0] ent_acc_ff;
   logic [FIELD_BITS-1:0] ent_base_ff;
   logic [FIELD_BITS-1:0] red_a;
   logic [FIELD_BITS-1:0] red_b;
   logic [FIELD_BITS:0]   add_sum;
   logic [FIELD_BITS-1:0] add_res;
   logic [FIELD_BITS-1:0] acc_in;
   logic [FIELD_BITS-1:0] base_in;
   cmd_type               cmd_in;

   logic                  out_v_ff;
   logic [FIELD_BITS-1:0] out_res_ff;

   assign adv = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_comb begin
      cmd_in  = cmd_type'(req_ch.cmd);
      red_a   = reduce_in(req_ch.operand_a);
      red_b   = reduce_in(req_ch.operand_b);
      add_sum = 62'(red_a) + 62'(red_b);
      if (add_sum >= 62'(FIELD_P)) begin
         add_res = FIELD_BITS'(add_sum - 62'(FIELD_P));
      end else begin
         add_res = add_sum[FIELD_BITS-1:0];
      end
      unique case (cmd_in)
         CMD_ADD: begin
            acc_in  = add_res;
            base_in = red_a;
         end
         CMD_MUL: begin
            acc_in  = red_a;
            base_in = red_b;
         end
         default: begin
            acc_in  = FIELD_BITS'(1);
            base_in = red_a;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_v_ff <= 1'b0;
      end else if (adv) begin
         ent_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_cmd_ff  <= cmd_in;
         ent_acc_ff  <= acc_in;
         ent_base_ff <= base_in;
      end
   end

   assign v_s[0]    = ent_v_ff;
   assign cmd_s[0]  = ent_cmd_ff;
   assign acc_s[0]  = ent_acc_ff;
   assign base_s[0] = ent_base_ff;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      logic [2:0]            v_ff;
      logic [2:0]            sel_ff;
      cmd_type               cmd_ff [3];
      logic [FIELD_BITS-1:0] acc_ff [3];
      logic [FIELD_BITS-1:0] mul_acc;
      logic [FIELD_BITS-1:0] mul_base;

      mfa_mul u_acc_mul (
         .clock   (clock),
         .enable  (adv),
         .a       (acc_s[r]),
         .b       (base_s[r]),
         .product (mul_acc)
      );

      mfa_mul u_sq_mul (
         .clock   (clock),
         .enable  (adv),
         .a       (base_s[r]),
         .b       (base_s[r]),
         .product (mul_base)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= '0;
         end else if (adv) begin
            v_ff <= {v_ff[1:0], v_s[r]};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sel_ff    <= {sel_ff[1:0], exp_bit(cmd_s[r], ROUND_W'(r))};
            cmd_ff[0] <= cmd_s[r];
            cmd_ff[1] <= cmd_ff[0];
            cmd_ff[2] <= cmd_ff[1];
            acc_ff[0] <= acc_s[r];
            acc_ff[1] <= acc_ff[0];
            acc_ff[2] <= acc_ff[1];
         end
      end

      assign v_s[r+1]    = v_ff[2];
      assign cmd_s[r+1]  = cmd_ff[2];
      assign acc_s[r+1]  = sel_ff[2] ? mul_acc : acc_ff[2];
      assign base_s[r+1] = mul_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_s[ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_res_ff <= acc_s[ROUNDS];
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.field_result = out_res_ff;

endmodule

`default_nettype wire

@@ sv/mfa_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfa_mul
   import mfa_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [FIELD_BITS-1:0] a,
   input  wire logic [FIELD_BITS-1:0] b,
   output logic      [FIELD_BITS-1:0] product
);

   logic [63:0]                 p00_ff;
   logic [60:0]                 p01_ff;
   logic [60:0]                 p10_ff;
   logic [57:0]                 p11_ff;
   logic [2*FIELD_BITS-1:0]     full_ff;
   logic [2*FIELD_BITS-1:0]     full_in;
   logic [FIELD_BITS:0]         fold_sum;
   logic [FIELD_BITS-1:0]       res_in;
   logic [FIELD_BITS-1:0]       res_ff;

   always_comb begin
      full_in = 122'(p00_ff) + ((122'(p01_ff) + 122'(p10_ff)) << 32) + (122'(p11_ff) << 64);
      fold_sum = 62'(full_ff[FIELD_BITS-1:0]) + 62'(full_ff[2*FIELD_BITS-1:FIELD_BITS]);
      if (fold_sum >= 62'(FIELD_P)) begin
         res_in = FIELD_BITS'(fold_sum - 62'(FIELD_P));
      end else begin
         res_in = fold_sum[FIELD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p00_ff  <= 64'(a[31:0]) * 64'(b[31:0]);
         p01_ff  <= 61'(a[31:0]) * 61'(b[60:32]);
         p10_ff  <= 61'(a[60:32]) * 61'(b[31:0]);
         p11_ff  <= 58'(a[60:32]) * 58'(b[60:32]);
         full_ff <= full_in;
         res_ff  <= res_in;
      end
   end

   assign product = res_ff;

endmodule

`default_nettype wire

@@ sv/mfa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mfa_checker
   import mfa_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [FIELD_BITS-1:0] field_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(field_result))
      else $error("Stalled result word changed.");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> field_result != FIELD_P)
      else $error("Result word is not reduced.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result word shown right after reset.");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("Input ready does not follow the output stall.");

endmodule

bind mersenne61_field_alu_unit mfa_checker u_mfa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .field_result (rsp_ch.field_result)
);

`default_nettype wire

@@ bench/tb_mersenne61_field_alu_unit.sv @@
`timescale 1ns / 1ps

module tb_mersenne61_field_alu_unit;
   import mfa_pkg::*;

   localparam logic [60:0] P = {61{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfa_req_if req_ch();
   mfa_rsp_if rsp_ch();

   mersenne61_field_alu_unit dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #10 clock = ~clock;

   logic [60:0] expected_results[$];
   int mismatch_count = 0;
   int result_count = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int idle_pct = 35;
   int hold_cycles = 0;

   task automatic report_mismatch(input string what, input logic [60:0] got,
                                  input logic [60:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic [60:0] field_reduce(input logic [60:0] v);
      return (v == P) ? '0 : v;
   endfunction

   function automatic logic [60:0] field_add(input logic [60:0] a, input logic [60:0] b);
      logic [61:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, P}) s = s - {1'b0, P};
      return s[60:0];
   endfunction

   function automatic logic [60:0] field_mul(input logic [60:0] a, input logic [60:0] b);
      logic [121:0] prod;
      logic [61:0] s;
      prod = {61'b0, a} * {61'b0, b};
      s = {1'b0, prod[60:0]} + {1'b0, prod[121:61]};
      if (s >= {1'b0, P}) s = s - {1'b0, P};
      return s[60:0];
   endfunction

   function automatic logic [60:0] field_pow(input logic [60:0] x, input logic [63:0] e);
      logic [60:0] acc;
      logic [60:0] base;
      acc = 61'd1;
      base = x;
      for (int i = 0; i < 61; i++) begin
         if (e[i]) acc = field_mul(acc, base);
         base = field_mul(base, base);
      end
      return acc;
   endfunction

   function automatic logic [60:0] predict_field_result(input cmd_type cmd,
                                                        input logic [60:0] a_in,
                                                        input logic [60:0] b_in);
      logic [60:0] a;
      logic [60:0] b;
      a = field_reduce(a_in);
      b = field_reduce(b_in);
      case (cmd)
         CMD_ADD:  return field_add(a, b);
         CMD_MUL:  return field_mul(a, b);
         CMD_INV:  return field_pow(a, 64'h1FFF_FFFF_FFFF_FFFD);
         default:  return field_pow(a, 64'h0800_0000_0000_0000);
      endcase
   endfunction

   task automatic send_word(input cmd_type cmd, input logic [60:0] a, input logic [60:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(predict_field_result(cmd, a, b));
      cmd_count[cmd]++;
      @(negedge clock);
   endtask

   function automatic logic [60:0] random_field();
      logic [60:0] v;
      v = 61'({$urandom, $urandom});
      case ($urandom_range(9))
         0: v = 61'($urandom_range(3));
         1: v = P - 61'($urandom_range(3));
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.field_result, '0);
         end else begin
            logic [60:0] want;
            want = expected_results.pop_front();
            if (rsp_ch.field_result !== want)
               report_mismatch("field_result", rsp_ch.field_result, want);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic test_extremes();
      logic [60:0] vals[6];
      vals = '{61'd0, 61'd1, 61'd2, P - 61'd1, P, 61'h0AAA_AAAA_AAAA_AAAA};
      foreach (vals[i]) begin
         send_word(CMD_ADD, vals[i], vals[5 - i]);
         send_word(CMD_MUL, vals[i], vals[(i + 3) % 6]);
      end
   endtask

   task automatic test_inverse_and_root();
      send_word(CMD_INV, 61'd0, P);
      send_word(CMD_INV, P, 61'd0);
      send_word(CMD_INV, P - 61'd1, 61'd5);
      send_word(CMD_SQRT, 61'd0, 61'd0);
      send_word(CMD_SQRT, 61'd4, 61'd0);
      send_word(CMD_SQRT, P - 61'd1, 61'd0);
      send_word(CMD_SQRT, 61'd3, P);
      send_word(CMD_INV, 61'd7, 61'd0);
   endtask

   task automatic test_random(input int count);
      repeat (count)
         send_word(cmd_type'($urandom_range(3)), random_field(), random_field());
   endtask

   task automatic test_back_pressure();
      hold_cycles = 400;
      test_random(250);
   endtask

   task automatic test_streaming();
      idle_pct = 0;
      test_random(300);
      idle_pct = 35;
   endtask

   initial begin
      int drain;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_ADD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_inverse_and_root();
      test_random(500);
      test_back_pressure();
      test_streaming();
      test_random(480);
      req_ch.valid <= 1'b0;
      drain = 0;
      while (expected_results.size() != 0 && drain < 200000) begin
         @(posedge clock);
         drain++;
      end
      repeat (400) @(posedge clock);
      $display("Covered %0d words: %0d add, %0d multiply, %0d inverse, %0d square root.",
               result_count, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
      if (expected_results.size() != 0) begin
         $display("%0d expected words never arrived", expected_results.size());
         mismatch_count += expected_results.size();
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
